// File: design/stereo_allpass_delay_filter_assert.svh
// Assertion helpers for the stereo all-pass filter.
// Each use expands to one labeled concurrent assertion, clocked on clk
// and switched off while rst_n is low.
`ifndef STEREO_ALLPASS_DELAY_FILTER_ASSERT_SVH
`define STEREO_ALLPASS_DELAY_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("all-pass filter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("all-pass filter assertion failed");

`endif

// File: design/saf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package saf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int FRAC_W     = 15;
    localparam int DELAY_W    = 12;
    localparam int CHAN_W     = 1;

    localparam int MAX_DELAY  = 4096;
    localparam int CHANNELS   = 2;
    localparam int POS_W      = $clog2(MAX_DELAY);
    localparam int MEM_AW     = CHAN_W + POS_W;
    localparam int MEM_DEPTH  = CHANNELS * MAX_DELAY;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd16384;
    localparam logic [GAIN_W-1:0]  GAIN_MIN    = 15'd9830;
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = 15'd29491;

    localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(MAX_DELAY - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

endpackage

`default_nettype wire

// File: design/saf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface saf_in_if;
    import saf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface saf_out_if;
    import saf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

`default_nettype wire

// File: design/stereo_allpass_delay_filter.sv
// Pipeline: an accepted item moves through the compute stage registers, then the
// result register. Throughput: one item per cycle unless the output stalls; each
// history memory reads once at accept and writes once as an item leaves compute.
// Reset: control, write positions and config registers return to defaults at once.
// History reads as zero until written, tracked by a per-channel wrap flag and the
// write position, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module stereo_allpass_delay_filter
(
    input  logic                            clk,
    input  logic                            rst_n,
    saf_in_if.sink                          din,
    saf_out_if.source                       dout,
    input  logic                            cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [saf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import saf_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int YQ_W   = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    // Configuration
    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_wr;

    always_comb
    begin
        gain_wr = cfg_data[GAIN_W-1:0];
        if (gain_wr < GAIN_MIN)
        begin
            gain_wr = GAIN_MIN;
        end
        if (gain_wr > GAIN_MAX)
        begin
            gain_wr = GAIN_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                REG_GAIN:  gain_reg  <= gain_wr;
                default:   ;
            endcase
        end
    end

    logic [POS_W-1:0] d_pos;

    always_comb
    begin
        if (delay_reg == '0)
        begin
            d_pos = POS_W'(1);
        end
        else if (DELAY_W'(delay_reg) > DELAY_W'(POS_LAST))
        begin
            d_pos = POS_LAST;
        end
        else
        begin
            d_pos = POS_W'(delay_reg);
        end
    end

    // Handshake and pipeline control
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s1_move;
    logic din_accept;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready  = !s1_valid_reg || s1_move;
    assign din_accept = din.valid && din.ready;

    // Per-channel write positions
    logic [POS_W-1:0]    wr_pos_reg [CHANNELS];
    logic [CHANNELS-1:0] wrapped_reg;
    logic [POS_W-1:0]    pos_cur;
    logic [POS_W-1:0]    rd_pos;
    logic                hist_ok;

    assign pos_cur = wr_pos_reg[din.channel];
    // The history length is a power of two, so the read position wraps by itself.
    assign rd_pos  = pos_cur - d_pos;
    // Entry rd_pos holds real data once the channel has wrapped or the read
    // position lies behind the write position.
    assign hist_ok = wrapped_reg[din.channel] || (pos_cur >= d_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wr_pos_reg[c] <= '0;
            end
            wrapped_reg <= '0;
        end
        else if (din_accept)
        begin
            wr_pos_reg[din.channel] <= pos_cur + POS_W'(1);
            if (pos_cur == POS_LAST)
            begin
                wrapped_reg[din.channel] <= 1'b1;
            end
        end
    end

    // Compute stage registers
    logic [CHAN_W-1:0]          s1_ch_reg;
    logic [POS_W-1:0]           s1_pos_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic                       s1_fwd_reg;
    logic                       s1_hok_reg;
    logic signed [SAMPLE_W-1:0] fwd_x_reg;
    logic signed [SAMPLE_W-1:0] fwd_y_reg;
    logic signed [SAMPLE_W-1:0] mem_x_reg;
    logic signed [SAMPLE_W-1:0] mem_y_reg;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       fwd_hit;

    // The entry the new item reads is being written by the item in the compute
    // stage on this same edge, so its values are taken straight from that stage.
    assign fwd_hit = s1_valid_reg && (s1_ch_reg == din.channel) && (s1_pos_reg == rd_pos);

    assign s1_valid_next = din_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din_accept)
        begin
            s1_ch_reg  <= din.channel;
            s1_pos_reg <= pos_cur;
            s1_x_reg   <= din.sample_in;
            s1_fwd_reg <= fwd_hit;
            s1_hok_reg <= hist_ok;
            fwd_x_reg  <= s1_x_reg;
            fwd_y_reg  <= y_sat;
        end
    end

    // History memories, one entry per channel and position
    logic signed [SAMPLE_W-1:0] in_mem  [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] out_mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            in_mem[MEM_AW'({s1_ch_reg, s1_pos_reg})]  <= s1_x_reg;
            out_mem[MEM_AW'({s1_ch_reg, s1_pos_reg})] <= y_sat;
        end
        if (din_accept)
        begin
            mem_x_reg <= in_mem[MEM_AW'({din.channel, rd_pos})];
            mem_y_reg <= out_mem[MEM_AW'({din.channel, rd_pos})];
        end
    end

    // y = xd + g * (yd - x), rounded half up and saturated
    logic signed [SAMPLE_W-1:0] xd;
    logic signed [SAMPLE_W-1:0] yd;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [YQ_W-1:0]     yq;

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            xd = fwd_x_reg;
            yd = fwd_y_reg;
        end
        else if (s1_hok_reg)
        begin
            xd = mem_x_reg;
            yd = mem_y_reg;
        end
        else
        begin
            xd = '0;
            yd = '0;
        end

        diff = DIFF_W'(yd) - DIFF_W'(s1_x_reg);
        prod = $signed({1'b0, gain_reg}) * diff;
        acc  = (ACC_W'(xd) <<< FRAC_W) + ACC_W'(prod) + ROUND_HALF;
        yq   = acc[ACC_W-1:FRAC_W];

        if (!yq[YQ_W-1] && (|yq[YQ_W-2:SAMPLE_W-1]))
        begin
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (yq[YQ_W-1] && !(&yq[YQ_W-2:SAMPLE_W-1]))
        begin
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            y_sat = yq[SAMPLE_W-1:0];
        end
    end

    // Result register
    logic [CHAN_W-1:0]          out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    assign out_valid_next = s1_move ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_ch_reg     <= s1_ch_reg;
            out_sample_reg <= y_sat;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.channel_out = out_ch_reg;
    assign dout.sample_out  = out_sample_reg;

`include "stereo_allpass_delay_filter_assert.svh"

    `SAF_ASSERT_NEXT(a_move_fills_result, s1_move, out_valid_reg)
    `SAF_ASSERT_NOW(a_accept_needs_room, din_accept, !s1_valid_reg || s1_move)
    `SAF_ASSERT_NEXT(a_forward_marked, din_accept && fwd_hit, s1_valid_reg && s1_fwd_reg)
    `SAF_ASSERT_NEXT(a_wrap_recorded, din_accept && (pos_cur == POS_LAST), wrapped_reg[s1_ch_reg])

endmodule

`default_nettype wire
